/* sv/life_grid_generation_engine_unit_assert.svh */
// Assertion macros for the life grid engine RTL.
`ifndef LIFE_GRID_GENERATION_ENGINE_UNIT_ASSERT_SVH
`define LIFE_GRID_GENERATION_ENGINE_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define LGGE_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define LGGE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/lgge_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package lgge_pkg;

  // Field widths fixed by the interface.
  localparam int OP_W      = 2;
  localparam int COORD_W   = 6;
  localparam int SIZE_W    = 7;
  localparam int GEN_W     = 32;
  localparam int CFG_IDX_W = 1;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
  localparam logic [OP_W-1:0] OP_READ  = 2'd1;
  localparam logic [OP_W-1:0] OP_STEP  = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = 1'd1;

  // Reset value of both size registers.
  localparam logic [SIZE_W-1:0] SIZE_RESET = 7'd64;

  // Neighbor counts of the B3/S23 rule.
  localparam logic [3:0] BIRTH_COUNT = 4'd3;
  localparam logic [3:0] KEEP_COUNT  = 4'd2;

  // Per-row control for the rule evaluator.
  typedef struct packed {
    logic active;
    logic has_above;
    logic has_below;
  } rule_ctl_t;

endpackage

`default_nettype wire

/* sv/lgge_row_cell.sv */
`timescale 1ns / 1ps
`default_nettype none

// One link of the row ring: holds one grid row and takes its neighbor's row on a shift.
module lgge_row_cell #(
  parameter int W = 64
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         shift,
  input  wire logic [W-1:0] d,
  output logic      [W-1:0] q
);

  // Rows come out of reset dead.
  always_ff @(posedge clk) begin
    if (rst) begin
      q <= '0;
    end else if (shift) begin
      q <= d;
    end
  end

endmodule

`default_nettype wire

/* sv/lgge_row_rule.sv */
`timescale 1ns / 1ps
`default_nettype none

// Evaluates the B3/S23 rule for a whole row from a three-row window.
module lgge_row_rule #(
  parameter int W = 64
) (
  input  wire lgge_pkg::rule_ctl_t ctl,
  input  wire logic [W-1:0]        col_mask,
  input  wire logic [W-1:0]        above,
  input  wire logic [W-1:0]        self_row,
  input  wire logic [W-1:0]        below,
  output logic      [W-1:0]        next_row
);

  logic [W+1:0] a_pad;
  logic [W+1:0] s_pad;
  logic [W+1:0] b_pad;

  // Cells outside the in-use area, and rows beyond the edges, read as dead.
  assign a_pad = {1'b0, above & col_mask & {W{ctl.has_above}}, 1'b0};
  assign s_pad = {1'b0, self_row & col_mask, 1'b0};
  assign b_pad = {1'b0, below & col_mask & {W{ctl.has_below}}, 1'b0};

  // Column j sits at bit j+1 of the padded rows.
  for (genvar j = 0; j < W; j++) begin : g_col
    logic [3:0] count;
    logic       fate;

    assign count = 4'(a_pad[j]) + 4'(a_pad[j+1]) + 4'(a_pad[j+2])
                 + 4'(s_pad[j])                  + 4'(s_pad[j+2])
                 + 4'(b_pad[j]) + 4'(b_pad[j+1]) + 4'(b_pad[j+2]);

    always_comb begin
      fate = (count == lgge_pkg::BIRTH_COUNT) ||
             ((count == lgge_pkg::KEEP_COUNT) && self_row[j]);
    end

    // Cells outside the in-use area keep their value.
    assign next_row[j] = (ctl.active && col_mask[j]) ? fate : self_row[j];
  end

endmodule

`default_nettype wire

/* sv/life_grid_generation_engine_unit.sv */
`timescale 1ns / 1ps
`default_nettype none

// Channel | Direction | Handshake            | Word
// cmd     | in        | cmd_valid/cmd_ready  | op, col, row, cell_in
// rsp     | out       | rsp_valid/rsp_ready  | cell_out, generation_out
// cfg     | in        | cfg_valid/cfg_ready  | cfg_index, cfg_data
//
// A command is accepted in ST_IDLE, sweeps the ring in ST_RUN and then waits in ST_DONE until its word
// enters the output register; no new command is taken until the engine is back in ST_IDLE.
// The grid is a ring of MAX_HEIGHT rows that turns once per command; every op acts at its head.
// Reset clears the grid, the generation count and sets both sizes to 64, with no clearing pass.
// A new command is taken while an earlier result still waits on rsp; a result that is not
// taken holds the engine in its final state until rsp_ready.
module life_grid_generation_engine_unit #(
  parameter int MAX_WIDTH  = 64,
  parameter int MAX_HEIGHT = 64
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cmd_valid,
  output logic                                   cmd_ready,
  input  wire logic [lgge_pkg::OP_W-1:0]         op,
  input  wire logic [lgge_pkg::COORD_W-1:0]      col,
  input  wire logic [lgge_pkg::COORD_W-1:0]      row,
  input  wire logic                              cell_in,
  output logic                                   rsp_valid,
  input  wire logic                              rsp_ready,
  output logic                                   cell_out,
  output logic      [lgge_pkg::GEN_W-1:0]        generation_out,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [lgge_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [lgge_pkg::SIZE_W-1:0]       cfg_data
);

  `include "life_grid_generation_engine_unit_assert.svh"

  localparam int CNT_W = $clog2(MAX_HEIGHT);
  localparam int CMP_W = ((CNT_W > lgge_pkg::SIZE_W) ? CNT_W : lgge_pkg::SIZE_W) + 1;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_DONE = 3'b100
  } state_t;

  state_t                          state;
  logic [CNT_W-1:0]                cnt;
  logic [lgge_pkg::OP_W-1:0]       op_q;
  logic [lgge_pkg::COORD_W-1:0]    col_q;
  logic [lgge_pkg::COORD_W-1:0]    row_q;
  logic                            cell_in_q;
  logic [lgge_pkg::SIZE_W-1:0]     width_reg;
  logic [lgge_pkg::SIZE_W-1:0]     height_reg;
  logic [lgge_pkg::GEN_W-1:0]      gen;
  logic [lgge_pkg::GEN_W-1:0]      gen_next;
  logic                            rd_bit;
  logic [MAX_WIDTH-1:0]            prev_row;

  logic [MAX_WIDTH-1:0]            rows [MAX_HEIGHT];
  logic [MAX_WIDTH-1:0]            head_row;
  logic [MAX_WIDTH-1:0]            tail_in;
  logic [MAX_WIDTH-1:0]            rule_row;
  logic [MAX_WIDTH-1:0]            col_mask;
  logic [MAX_WIDTH-1:0]            col_sel;
  logic [lgge_pkg::SIZE_W-1:0]     used_w;
  logic [CMP_W-1:0]                used_h;
  logic [CMP_W-1:0]                cnt_ext;
  logic [CMP_W-1:0]                row_ext;
  logic                            in_area;
  logic                            row_hit;
  logic                            last;
  logic                            shift;
  logic                            handoff;
  logic                            step_end;
  lgge_pkg::rule_ctl_t             ctl;

  // Sizes above the maximum act as the maximum.
  assign used_w = (width_reg > lgge_pkg::SIZE_W'(MAX_WIDTH)) ?
                  lgge_pkg::SIZE_W'(MAX_WIDTH) : width_reg;
  assign used_h = (CMP_W'(height_reg) > CMP_W'(MAX_HEIGHT)) ?
                  CMP_W'(MAX_HEIGHT) : CMP_W'(height_reg);

  assign cnt_ext  = CMP_W'(cnt);
  assign row_ext  = CMP_W'(row_q);
  assign in_area  = (lgge_pkg::SIZE_W'(col_q) < used_w) && (row_ext < used_h);
  assign row_hit  = in_area && (cnt_ext == row_ext);
  assign last     = (cnt == CNT_W'(MAX_HEIGHT - 1));
  assign shift    = (state == ST_RUN);
  assign handoff  = (state == ST_DONE) && (!rsp_valid || rsp_ready);
  assign step_end = shift && last && (op_q == lgge_pkg::OP_STEP);
  assign gen_next = gen + lgge_pkg::GEN_W'(1);

  assign cmd_ready = (state == ST_IDLE);
  assign cfg_ready = 1'b1;

  // Column masks: in-use columns and the addressed column.
  for (genvar j = 0; j < MAX_WIDTH; j++) begin : g_mask
    assign col_mask[j] = (lgge_pkg::SIZE_W'(j) < used_w);
    assign col_sel[j]  = (col_q == lgge_pkg::COORD_W'(j));
  end

  // Window control for the row now at the head of the ring.
  always_comb begin
    ctl.active    = (cnt_ext < used_h);
    ctl.has_above = (cnt != '0);
    ctl.has_below = ((cnt_ext + CMP_W'(1)) < used_h);
  end

  assign head_row = rows[0];

  lgge_row_rule #(
    .W (MAX_WIDTH)
  ) u_rule (
    .ctl      (ctl),
    .col_mask (col_mask),
    .above    (prev_row),
    .self_row (head_row),
    .below    (rows[1]),
    .next_row (rule_row)
  );

  // The row leaving the head re-enters at the tail, updated as the command asks.
  always_comb begin
    case (op_q)
      lgge_pkg::OP_STEP: begin
        tail_in = rule_row;
      end
      lgge_pkg::OP_WRITE: begin
        tail_in = row_hit ? ((head_row & ~col_sel) | (col_sel & {MAX_WIDTH{cell_in_q}}))
                          : head_row;
      end
      default: begin
        tail_in = head_row;
      end
    endcase
  end

  // Ring of row registers, each passing its row toward the head.
  for (genvar i = 0; i < MAX_HEIGHT; i++) begin : g_ring
    if (i == MAX_HEIGHT - 1) begin : g_tail
      lgge_row_cell #(
        .W (MAX_WIDTH)
      ) u_cell (
        .clk   (clk),
        .rst   (rst),
        .shift (shift),
        .d     (tail_in),
        .q     (rows[i])
      );
    end else begin : g_link
      lgge_row_cell #(
        .W (MAX_WIDTH)
      ) u_cell (
        .clk   (clk),
        .rst   (rst),
        .shift (shift),
        .d     (rows[i+1]),
        .q     (rows[i])
      );
    end
  end

  // Control: sequencer, size registers, generation count and output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      cnt        <= '0;
      gen        <= '0;
      width_reg  <= lgge_pkg::SIZE_RESET;
      height_reg <= lgge_pkg::SIZE_RESET;
      rsp_valid  <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          lgge_pkg::CFG_GRID_WIDTH:  width_reg  <= cfg_data;
          lgge_pkg::CFG_GRID_HEIGHT: height_reg <= cfg_data;
          default: ;
        endcase
      end
      // A new word enters the output register, or a taken word leaves it.
      if (handoff) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (cmd_valid) begin
            state <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (last) begin
            cnt   <= '0;
            state <= ST_DONE;
            if (op_q == lgge_pkg::OP_STEP) begin
              gen <= gen_next;
            end
          end else begin
            cnt <= cnt + CNT_W'(1);
          end
        end
        ST_DONE: begin
          if (handoff) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Datapath: command word, row above the head, read bit and output word.
  always_ff @(posedge clk) begin
    if (cmd_valid && cmd_ready) begin
      op_q      <= op;
      col_q     <= col;
      row_q     <= row;
      cell_in_q <= cell_in;
      rd_bit    <= 1'b0;
    end
    if (shift) begin
      prev_row <= head_row;
      if (row_hit && (op_q == lgge_pkg::OP_READ)) begin
        rd_bit <= |(head_row & col_sel);
      end
    end
    if (handoff) begin
      cell_out       <= rd_bit;
      generation_out <= gen;
    end
  end

  // Checks on the sequencer and the generation count.
  `LGGE_ASSERT_NOW(a_idle_cnt_clear, clk, rst, state == ST_IDLE, cnt == '0, "count not clear")
  `LGGE_ASSERT_NEXT(a_accept_runs, clk, rst, cmd_valid && cmd_ready, state == ST_RUN, "no sweep")
  `LGGE_ASSERT_NEXT(a_gen_counts, clk, rst, step_end, gen == $past(gen_next), "step not counted")
  `LGGE_ASSERT_NEXT(a_gen_holds, clk, rst, !step_end, $stable(gen), "count moved off a step")
  `LGGE_ASSERT_NEXT(a_handoff_valid, clk, rst, handoff, rsp_valid && state == ST_IDLE, "no word")

endmodule

`default_nettype wire
